/* hw/rtl/tcppb_pkg.sv */
// Package for the two-class priority packet buffer.
// Holds request codes, controller states, the command struct and default sizes.
// No dependencies.
package tcppb_pkg;

  // Default sizes
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  // Limit register
  localparam int MAX_SIZE_W = 5;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RST = 5'd16;

  // Request codes; code 3 is a no-op
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // apply the captured request and register its result
  } dp_cmd_t;

endpackage

/* hw/rtl/tcppb_ctrl.sv */
// Controller of the two-class priority packet buffer.
// Sequences capture and execution of one request word; uses tcppb_pkg.
module tcppb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output tcppb_pkg::dp_cmd_t cmd
);

  tcppb_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcppb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    busy      = 1'b0;
    case (state_r)
      tcppb_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = tcppb_pkg::ST_EXEC;
        end
      end
      tcppb_pkg::ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = tcppb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcppb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/tcppb_dp.sv */
// Datapath of the two-class priority packet buffer.
// Two ring stores with head/count registers, limit register and result registers;
// uses tcppb_pkg, driven by tcppb_ctrl.
module tcppb_dp #(
  parameter int DEPTH   = tcppb_pkg::DEPTH_DEF,
  parameter int ID_BITS = tcppb_pkg::ID_BITS_DEF,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW     = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcppb_pkg::dp_cmd_t               cmd,
  input  logic [1:0]                       in_func,
  input  logic [ID_BITS-1:0]               in_packet_id,
  input  logic                             in_is_control,
  input  logic                             cfg_we,
  input  logic [tcppb_pkg::MAX_SIZE_W-1:0] cfg_data,
  output logic                             out_valid,
  output logic                             out_accepted,
  output logic                             out_pop_valid,
  output logic [ID_BITS-1:0]               out_packet_id,
  output logic                             out_is_control,
  output logic [CW-1:0]                    out_occupancy
);

  localparam int SW  = CW + 1;
  localparam int MW  = (SW > tcppb_pkg::MAX_SIZE_W) ? SW : tcppb_pkg::MAX_SIZE_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Ring position of head plus offset
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
                                            input logic [CW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(offs);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  // Captured request word
  logic [1:0]         func_r;
  logic [ID_BITS-1:0] id_r;
  logic               ctrl_r;

  // Class state and limit
  logic [AW-1:0] c_head_r, c_head_nxt, d_head_r, d_head_nxt;
  logic [CW-1:0] c_cnt_r, c_cnt_nxt, d_cnt_r, d_cnt_nxt;
  logic [tcppb_pkg::MAX_SIZE_W-1:0] max_size_r;

  // Stores and their registered head reads
  logic [ID_BITS-1:0] c_mem [DEPTH];
  logic [ID_BITS-1:0] d_mem [DEPTH];
  logic [ID_BITS-1:0] c_rd_r, d_rd_r;

  // Result registers
  logic               valid_r, acc_r, popv_r, cls_r;
  logic               acc_nxt, popv_nxt, cls_nxt;
  logic [ID_BITS-1:0] id_out_r, id_out_nxt;
  logic [CW-1:0]      occ_r;

  logic          c_we, d_we;
  logic [AW-1:0] c_wa, d_wa;
  logic [SW-1:0] total;
  logic          full, at_depth;

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      id_r   <= in_packet_id;
      ctrl_r <= in_is_control;
    end
  end

  // Write and read the stores
  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_wa] <= id_r;
    end
    if (d_we) begin
      d_mem[d_wa] <= id_r;
    end
    c_rd_r <= c_mem[c_head_r];
    d_rd_r <= d_mem[d_head_r];
  end

  // Decide the request outcome
  always_comb begin
    total      = SW'(c_cnt_r) + SW'(d_cnt_r);
    full       = MW'(total) >= MW'(max_size_r);
    at_depth   = total >= DEPTH_S;
    c_wa       = ring_at(c_head_r, c_cnt_r);
    d_wa       = ring_at(d_head_r, d_cnt_r);
    c_we       = 1'b0;
    d_we       = 1'b0;
    c_head_nxt = c_head_r;
    d_head_nxt = d_head_r;
    c_cnt_nxt  = c_cnt_r;
    d_cnt_nxt  = d_cnt_r;
    acc_nxt    = 1'b1;
    popv_nxt   = 1'b0;
    cls_nxt    = 1'b0;
    id_out_nxt = '0;
    case (func_r)
      tcppb_pkg::FUNC_PUSH: begin
        if (ctrl_r) begin
          if ((full && (d_cnt_r == '0)) || at_depth) begin
            acc_nxt = 1'b0;
          end else begin
            c_we      = cmd.exec;
            c_cnt_nxt = c_cnt_r + CW'(1);
          end
        end else begin
          if (full || at_depth) begin
            acc_nxt = 1'b0;
          end else begin
            d_we      = cmd.exec;
            d_cnt_nxt = d_cnt_r + CW'(1);
          end
        end
      end
      tcppb_pkg::FUNC_POP: begin
        if (c_cnt_r != '0) begin
          id_out_nxt = c_rd_r;
          cls_nxt    = 1'b1;
          popv_nxt   = 1'b1;
          c_head_nxt = (c_head_r == LAST_A) ? '0 : c_head_r + AW'(1);
          c_cnt_nxt  = c_cnt_r - CW'(1);
        end else if (d_cnt_r != '0) begin
          id_out_nxt = d_rd_r;
          popv_nxt   = 1'b1;
          d_head_nxt = (d_head_r == LAST_A) ? '0 : d_head_r + AW'(1);
          d_cnt_nxt  = d_cnt_r - CW'(1);
        end
      end
      tcppb_pkg::FUNC_CLEAR: begin
        c_head_nxt = '0;
        d_head_nxt = '0;
        c_cnt_nxt  = '0;
        d_cnt_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Update class state and limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_head_r   <= '0;
      d_head_r   <= '0;
      c_cnt_r    <= '0;
      d_cnt_r    <= '0;
      max_size_r <= tcppb_pkg::MAX_SIZE_RST;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cfg_we) begin
        max_size_r <= cfg_data;
      end
      if (cmd.exec) begin
        c_head_r <= c_head_nxt;
        d_head_r <= d_head_nxt;
        c_cnt_r  <= c_cnt_nxt;
        d_cnt_r  <= d_cnt_nxt;
      end
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r    <= acc_nxt;
      popv_r   <= popv_nxt;
      cls_r    <= cls_nxt;
      id_out_r <= id_out_nxt;
      occ_r    <= c_cnt_nxt + d_cnt_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_accepted   = acc_r;
  assign out_pop_valid  = popv_r;
  assign out_packet_id  = id_out_r;
  assign out_is_control = cls_r;
  assign out_occupancy  = occ_r;

endmodule

/* hw/rtl/two_class_priority_packet_buffer.sv */
// Two-class priority packet buffer: control packets ahead of data packets.
// Each word is captured, then executed in ST_EXEC; out_valid marks its registered result.
// A new word is taken only in ST_IDLE, after the capture and execute steps; busy marks ST_EXEC.
// The receiver cannot stall; each result stands for exactly one cycle.
// Synchronous active-low reset empties both classes and sets max_size to 16.
// Uses tcppb_pkg, tcppb_ctrl and tcppb_dp.
module two_class_priority_packet_buffer #(
  parameter int DEPTH   = tcppb_pkg::DEPTH_DEF,
  parameter int ID_BITS = tcppb_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic [ID_BITS-1:0]               in_packet_id,
  input  logic                             in_is_control,
  input  logic                             cfg_we,
  input  logic [tcppb_pkg::MAX_SIZE_W-1:0] cfg_data,
  output logic                             out_valid,
  output logic                             out_accepted,
  output logic                             out_pop_valid,
  output logic [ID_BITS-1:0]               out_packet_id,
  output logic                             out_is_control,
  output logic [$clog2(DEPTH+1)-1:0]       out_occupancy
);

  tcppb_pkg::dp_cmd_t cmd;

  // Sequence each request word
  tcppb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold packets and compute results
  tcppb_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_func),
    .in_packet_id   (in_packet_id),
    .in_is_control  (in_is_control),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .out_pop_valid  (out_pop_valid),
    .out_packet_id  (out_packet_id),
    .out_is_control (out_is_control),
    .out_occupancy  (out_occupancy)
  );

endmodule

/* hw/rtl/tcppb_checker.sv */
// Port checker for the two-class priority packet buffer, bound to the top level.
// Watches only top-level ports; uses tcppb_pkg.
module tcppb_checker #(
  parameter int DEPTH   = tcppb_pkg::DEPTH_DEF,
  parameter int ID_BITS = tcppb_pkg::ID_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_accepted,
  input logic                       out_pop_valid,
  input logic [ID_BITS-1:0]         out_packet_id,
  input logic                       out_is_control,
  input logic [$clog2(DEPTH+1)-1:0] out_occupancy
);

  // Accepted word is followed by busy and then by a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy ##1 out_valid)
    else $error("accepted word gave no result");

  // A result only follows a busy cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in work");

  // Empty or non-pop results carry no packet
  a_no_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pop_valid |-> (out_packet_id == '0) && !out_is_control)
    else $error("packet fields set without a popped packet");

  // A pop is never reported as dropped
  a_pop_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pop_valid |-> out_accepted)
    else $error("popped packet reported as dropped");

  // Occupancy stays within the store
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_occupancy) <= 32'(DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind two_class_priority_packet_buffer tcppb_checker #(
  .DEPTH   (DEPTH),
  .ID_BITS (ID_BITS)
) u_tcppb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_pop_valid  (out_pop_valid),
  .out_packet_id  (out_packet_id),
  .out_is_control (out_is_control),
  .out_occupancy  (out_occupancy)
);
